/* rtl/cts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_pkg
// Types, codes and character helpers shared by the token scanner modules.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int LENGTH_BITS = 12;
    localparam int LINE_BITS   = 20;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    // scan modes
    localparam logic [4:0] M_IDLE   = 5'd0;
    localparam logic [4:0] M_NAME   = 5'd1;
    localparam logic [4:0] M_LPRE   = 5'd2;
    localparam logic [4:0] M_ZERO   = 5'd3;
    localparam logic [4:0] M_DEC    = 5'd4;
    localparam logic [4:0] M_HEX    = 5'd5;
    localparam logic [4:0] M_OCT    = 5'd6;
    localparam logic [4:0] M_FRAC   = 5'd7;
    localparam logic [4:0] M_EXP    = 5'd8;
    localparam logic [4:0] M_EXPSGN = 5'd9;
    localparam logic [4:0] M_EXPDIG = 5'd10;
    localparam logic [4:0] M_SUF    = 5'd11;
    localparam logic [4:0] M_DOT    = 5'd12;
    localparam logic [4:0] M_DOTDOT = 5'd13;
    localparam logic [4:0] M_OP1    = 5'd14;
    localparam logic [4:0] M_OP2    = 5'd15;
    localparam logic [4:0] M_STR    = 5'd16;
    localparam logic [4:0] M_STRESC = 5'd17;
    localparam logic [4:0] M_CHR1   = 5'd18;
    localparam logic [4:0] M_CHR    = 5'd19;
    localparam logic [4:0] M_CHRESC = 5'd20;

    // token kinds
    localparam logic [5:0] K_SINGLE     = 6'd0;
    localparam logic [5:0] K_NAME       = 6'd1;
    localparam logic [5:0] K_STR        = 6'd2;
    localparam logic [5:0] K_WSTR       = 6'd3;
    localparam logic [5:0] K_CHR        = 6'd4;
    localparam logic [5:0] K_WCHR       = 6'd5;
    localparam logic [5:0] K_INT_DEC    = 6'd6;
    localparam logic [5:0] K_INT_OCT    = 6'd8;
    localparam logic [5:0] K_INT_HEX    = 6'd10;
    localparam logic [5:0] K_FLT_F      = 6'd12;
    localparam logic [5:0] K_FLT        = 6'd13;
    localparam logic [5:0] K_DEC_DEC    = 6'd14;
    localparam logic [5:0] K_SUB_EQ     = 6'd15;
    localparam logic [5:0] K_ARROW_STAR = 6'd16;
    localparam logic [5:0] K_ARROW      = 6'd17;
    localparam logic [5:0] K_INC        = 6'd18;
    localparam logic [5:0] K_ADD_EQ     = 6'd19;
    localparam logic [5:0] K_MUL_EQ     = 6'd20;
    localparam logic [5:0] K_DIV_EQ     = 6'd21;
    localparam logic [5:0] K_MOD_EQ     = 6'd22;
    localparam logic [5:0] K_LE         = 6'd23;
    localparam logic [5:0] K_SHL_EQ     = 6'd24;
    localparam logic [5:0] K_SHL        = 6'd25;
    localparam logic [5:0] K_GE         = 6'd26;
    localparam logic [5:0] K_SHR_EQ     = 6'd27;
    localparam logic [5:0] K_SHR        = 6'd28;
    localparam logic [5:0] K_EQ         = 6'd29;
    localparam logic [5:0] K_NE         = 6'd30;
    localparam logic [5:0] K_XOR_EQ     = 6'd31;
    localparam logic [5:0] K_AND_EQ     = 6'd32;
    localparam logic [5:0] K_LAND       = 6'd33;
    localparam logic [5:0] K_OR_EQ      = 6'd34;
    localparam logic [5:0] K_LOR        = 6'd35;
    localparam logic [5:0] K_SCOPE      = 6'd36;
    localparam logic [5:0] K_DOT_STAR   = 6'd37;
    localparam logic [5:0] K_ELLIPSIS   = 6'd38;
    localparam logic [5:0] K_END        = 6'd39;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_DOT       = 3'd1;
    localparam logic [2:0] E_OPEN_STR  = 3'd2;
    localparam logic [2:0] E_EMPTY_CHR = 3'd3;
    localparam logic [2:0] E_OPEN_CHR  = 3'd4;
    localparam logic [2:0] E_NO_HEX    = 3'd5;
    localparam logic [2:0] E_NO_EXP    = 3'd6;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_input;
    } t_cts_in;

    typedef struct packed {
        logic [5:0]             token_kind;
        logic [7:0]             single_char;
        logic [LENGTH_BITS-1:0] token_length;
        logic [LINE_BITS-1:0]   line_number;
        logic [2:0]             error_code;
        logic                   suffix_warning;
        logic                   last;
    } t_cts_out;

    typedef struct packed {
        logic [4:0]             mode;
        logic [7:0]             held0;
        logic                   held1;
        logic [LENGTH_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic [1:0]             suf;
        logic [2:0]             perr;
    } t_scan_st;

    function automatic logic is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_oct(logic [7:0] b);
        return b >= "0" && b <= "7";
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_hex(logic [7:0] b);
        return is_dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
    endfunction

    function automatic logic is_namech(logic [7:0] b);
        return is_alpha(b) || is_dig(b) || b == "_";
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] b);
        return (b >= "a" && b <= "z") ? b - 8'd32 : b;
    endfunction

    function automatic logic is_opstart(logic [7:0] b);
        return b == "-" || b == "+" || b == "*" || b == "/" || b == "%" || b == "<" ||
               b == ">" || b == "=" || b == "!" || b == "^" || b == "&" || b == "|" ||
               b == ":";
    endfunction

    function automatic logic [LENGTH_BITS-1:0] len_add(logic [LENGTH_BITS-1:0] len,
                                                        logic [1:0] n);
        logic [LENGTH_BITS:0] t;
        t = {1'b0, len} + {{(LENGTH_BITS-1){1'b0}}, n};
        return (t > {1'b0, LEN_MAX}) ? LEN_MAX : t[LENGTH_BITS-1:0];
    endfunction

    // two-character operator from first byte f and second byte b, K_SINGLE if none
    function automatic logic [5:0] op_pair(logic [7:0] f, logic [7:0] b);
        logic [5:0] k;
        k = K_SINGLE;
        case (f)
            "-": k = (b == "-") ? K_DEC_DEC : (b == "=") ? K_SUB_EQ : K_SINGLE;
            "+": k = (b == "+") ? K_INC : (b == "=") ? K_ADD_EQ : K_SINGLE;
            "*": k = (b == "=") ? K_MUL_EQ : K_SINGLE;
            "/": k = (b == "=") ? K_DIV_EQ : K_SINGLE;
            "%": k = (b == "=") ? K_MOD_EQ : K_SINGLE;
            "<": k = (b == "=") ? K_LE : K_SINGLE;
            ">": k = (b == "=") ? K_GE : K_SINGLE;
            "=": k = (b == "=") ? K_EQ : K_SINGLE;
            "!": k = (b == "=") ? K_NE : K_SINGLE;
            "^": k = (b == "=") ? K_XOR_EQ : K_SINGLE;
            "&": k = (b == "=") ? K_AND_EQ : (b == "&") ? K_LAND : K_SINGLE;
            "|": k = (b == "=") ? K_OR_EQ : (b == "|") ? K_LOR : K_SINGLE;
            ":": k = (b == ":") ? K_SCOPE : K_SINGLE;
            default: k = K_SINGLE;
        endcase
        return k;
    endfunction

endpackage

/* rtl/cts_scan_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_scan_stage
// One scan of a byte against the scanner state; flags a rescan when the byte
// ends a token without belonging to it.
// ----------------------------------------------------------------------------
module cts_scan_stage import cts_pkg::*; (
    input  logic     i_active,
    input  t_cts_in  i_item,
    input  t_scan_st i_st,
    output t_scan_st o_st,
    output logic     o_active,
    output logic     o_emit,
    output t_cts_out o_res
);

    logic       eoi;
    logic [7:0] b;
    t_scan_st   st;
    logic       cons;
    logic       fin;
    logic [5:0] fk;
    logic [7:0] fc;
    logic       clr_line;
    logic [7:0] sfx;
    logic [7:0] ub;
    logic [1:0] sbit;
    logic [5:0] opk;
    logic [7:0] hit;

    always_comb begin
        eoi      = i_item.end_of_input;
        b        = i_item.src_byte;
        st       = i_st;
        cons     = 1'b1;
        fin      = 1'b0;
        fk       = K_SINGLE;
        fc       = 8'd0;
        clr_line = 1'b0;
        sfx      = (i_st.held0 == {2'b00, K_FLT}) ? "F" : "U";
        ub       = to_upper(b);
        sbit     = (ub == "L") ? 2'b01 : 2'b10;
        opk      = eoi ? K_SINGLE : op_pair(i_st.held0, b);
        hit      = (i_st.held0 == "-") ? "*" : "=";
        o_res    = '0;

        unique case (i_st.mode) inside
            M_IDLE: begin
                if (eoi) begin
                    fin      = 1'b1;
                    fk       = K_END;
                    clr_line = 1'b1;
                end else if (b == " " || b == "\t") begin
                end else if (b == "\n") begin
                    if (st.line != LINE_MAX) st.line = st.line + 1'b1;
                end else begin
                    st.held0 = 8'd0;
                    st.held1 = 1'b0;
                    st.suf   = 2'd0;
                    st.perr  = E_NONE;
                    st.len   = {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    if (is_alpha(b) || b == "_") begin
                        st.mode = (b == "L") ? M_LPRE : M_NAME;
                    end else if (b == "0") begin
                        st.mode = M_ZERO;
                    end else if (is_dig(b)) begin
                        st.mode = M_DEC;
                    end else if (b == ".") begin
                        st.mode = M_DOT;
                    end else if (b == "\"") begin
                        st.mode  = M_STR;
                        st.held0 = {2'b00, K_STR};
                    end else if (b == "'") begin
                        st.mode  = M_CHR1;
                        st.held0 = {2'b00, K_CHR};
                    end else if (is_opstart(b)) begin
                        st.mode  = M_OP1;
                        st.held0 = b;
                    end else begin
                        fin = 1'b1;
                        fc  = b;
                    end
                end
            end
            M_NAME: begin
                if (!eoi && is_namech(b)) begin
                    st.len = len_add(st.len, 2'd1);
                end else begin
                    fin  = 1'b1;
                    fk   = K_NAME;
                    cons = 1'b0;
                end
            end
            M_LPRE: begin
                if (!eoi && b == "'") begin
                    st.len   = len_add(st.len, 2'd1);
                    st.mode  = M_CHR1;
                    st.held0 = {2'b00, K_WCHR};
                end else if (!eoi && b == "\"") begin
                    st.len   = len_add(st.len, 2'd1);
                    st.mode  = M_STR;
                    st.held0 = {2'b00, K_WSTR};
                end else begin
                    st.mode = M_NAME;
                    cons    = 1'b0;
                end
            end
            M_ZERO, M_DEC: begin
                if (!eoi && i_st.mode == M_DEC && is_dig(b)) begin
                    st.len = len_add(st.len, 2'd1);
                end else if (!eoi && b == ".") begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_FRAC;
                end else if (!eoi && (b == "e" || b == "E")) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_EXP;
                end else if (!eoi && i_st.mode == M_ZERO && (b == "x" || b == "X")) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_HEX;
                    st.perr = E_NO_HEX;
                end else if (!eoi && i_st.mode == M_ZERO && is_oct(b)) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_OCT;
                end else begin
                    st.mode  = M_SUF;
                    st.held0 = {2'b00, K_INT_DEC};
                    cons     = 1'b0;
                end
            end
            M_HEX: begin
                if (!eoi && is_hex(b)) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.perr = E_NONE;
                end else begin
                    st.mode  = M_SUF;
                    st.held0 = {2'b00, K_INT_HEX};
                    cons     = 1'b0;
                end
            end
            M_OCT: begin
                if (!eoi && is_oct(b)) begin
                    st.len = len_add(st.len, 2'd1);
                end else begin
                    st.mode  = M_SUF;
                    st.held0 = {2'b00, K_INT_OCT};
                    cons     = 1'b0;
                end
            end
            M_FRAC: begin
                if (!eoi && is_dig(b)) begin
                    st.len = len_add(st.len, 2'd1);
                end else if (!eoi && (b == "e" || b == "E")) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_EXP;
                end else begin
                    st.mode  = M_SUF;
                    st.held0 = {2'b00, K_FLT};
                    cons     = 1'b0;
                end
            end
            M_EXP, M_EXPSGN: begin
                if (!eoi && i_st.mode == M_EXP && (b == "+" || b == "-")) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_EXPSGN;
                end else if (!eoi && is_dig(b)) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_EXPDIG;
                end else begin
                    st.perr = E_NO_EXP;
                    fin     = 1'b1;
                    fk      = K_FLT;
                    cons    = 1'b0;
                end
            end
            M_EXPDIG: begin
                if (!eoi && is_dig(b)) begin
                    st.len = len_add(st.len, 2'd1);
                end else begin
                    st.mode  = M_SUF;
                    st.held0 = {2'b00, K_FLT};
                    cons     = 1'b0;
                end
            end
            M_SUF: begin
                if (!eoi && (ub == "L" || ub == sfx)) begin
                    if ((st.suf & sbit) != 2'd0) begin
                        st.held1 = 1'b1;
                    end else begin
                        st.suf = st.suf | sbit;
                        st.len = len_add(st.len, 2'd1);
                    end
                end else begin
                    fin  = 1'b1;
                    cons = 1'b0;
                    if (i_st.held0 == {2'b00, K_FLT}) begin
                        fk = st.suf[1] ? K_FLT_F : K_FLT;
                    end else begin
                        fk = i_st.held0[5:0] + {5'd0, st.suf[1]};
                    end
                end
            end
            M_DOT: begin
                if (!eoi && b == "*") begin
                    st.len = len_add(st.len, 2'd1);
                    fin    = 1'b1;
                    fk     = K_DOT_STAR;
                end else if (!eoi && b == ".") begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_DOTDOT;
                end else if (!eoi && is_dig(b)) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_FRAC;
                end else begin
                    fin  = 1'b1;
                    fc   = ".";
                    cons = 1'b0;
                end
            end
            M_DOTDOT: begin
                st.len = LENGTH_BITS'(3);
                fin    = 1'b1;
                fk     = K_ELLIPSIS;
                if (eoi || b != ".") begin
                    st.perr = E_DOT;
                    cons    = 1'b0;
                end
            end
            M_OP1: begin
                if (opk != K_SINGLE) begin
                    st.len = len_add(st.len, 2'd1);
                    fin    = 1'b1;
                    fk     = opk;
                end else if (!eoi && ((i_st.held0 == "-" && b == ">") ||
                                      (i_st.held0 == "<" && b == "<") ||
                                      (i_st.held0 == ">" && b == ">"))) begin
                    st.len  = len_add(st.len, 2'd1);
                    st.mode = M_OP2;
                end else begin
                    fin  = 1'b1;
                    fc   = i_st.held0;
                    cons = 1'b0;
                end
            end
            M_OP2: begin
                fin = 1'b1;
                if (!eoi && b == hit) begin
                    st.len = len_add(st.len, 2'd1);
                    fk     = (i_st.held0 == "-") ? K_ARROW_STAR :
                             (i_st.held0 == "<") ? K_SHL_EQ : K_SHR_EQ;
                end else begin
                    fk   = (i_st.held0 == "-") ? K_ARROW :
                           (i_st.held0 == "<") ? K_SHL : K_SHR;
                    cons = 1'b0;
                end
            end
            M_STR, M_CHR: begin
                st.len = len_add(st.len, 2'd1);
                if (!eoi && b == ((i_st.mode == M_STR) ? "\"" : "'")) begin
                    fin = 1'b1;
                    fk  = i_st.held0[5:0];
                end else if (!eoi && b == "\\") begin
                    st.mode = (i_st.mode == M_STR) ? M_STRESC : M_CHRESC;
                end else if (eoi || b == "\n") begin
                    st.perr = (i_st.mode == M_STR) ? E_OPEN_STR : E_OPEN_CHR;
                    fin     = 1'b1;
                    fk      = i_st.held0[5:0];
                    cons    = 1'b0;
                end
            end
            M_STRESC, M_CHRESC: begin
                st.mode = (i_st.mode == M_STRESC) ? M_STR : M_CHR;
                if (!eoi && (b == "\\" || b == ((i_st.mode == M_STRESC) ? "\"" : "'")))
                begin
                    st.len = len_add(st.len, 2'd1);
                end else begin
                    cons = 1'b0;
                end
            end
            M_CHR1: begin
                if (!eoi && b == "'") begin
                    st.len  = len_add(st.len, 2'd3);
                    st.perr = E_EMPTY_CHR;
                    fin     = 1'b1;
                    fk      = i_st.held0[5:0];
                end else begin
                    st.mode = M_CHR;
                    cons    = 1'b0;
                end
            end
            default: begin
                st.mode  = M_IDLE;
                st.held0 = 8'd0;
                st.held1 = 1'b0;
                st.len   = '0;
                st.suf   = 2'd0;
                st.perr  = E_NONE;
                cons     = 1'b0;
            end
        endcase

        if (fin) begin
            o_res.token_kind     = fk;
            o_res.single_char    = fc;
            o_res.token_length   = st.len;
            o_res.line_number    = st.line;
            o_res.error_code     = st.perr;
            o_res.suffix_warning = st.held1;
            o_res.last           = 1'b0;
            st.mode  = M_IDLE;
            st.held0 = 8'd0;
            st.held1 = 1'b0;
            st.len   = '0;
            st.suf   = 2'd0;
            st.perr  = E_NONE;
        end
        if (clr_line) st.line = '0;

        o_st     = i_active ? st : i_st;
        o_emit   = i_active && fin;
        o_active = i_active && !cons;
    end

endmodule

/* rtl/cts_res_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cts_res_queue
// Four-entry result queue; takes i_wr_cnt items a cycle, hands out one while i_ready is high.
// ----------------------------------------------------------------------------
module cts_res_queue import cts_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_wr_cnt,
    input  t_cts_out   i_wr_data [4],
    output logic [2:0] o_count,
    output logic       o_valid,
    input  logic       i_ready,
    output t_cts_out   o_data
);

    t_cts_out   r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;
    assign n_cnt   = r_cnt + i_wr_cnt - {2'b00, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + i_wr_cnt[1:0];
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < i_wr_cnt) r_mem[r_wp + 2'(k)] <= i_wr_data[k];
        end
    end

endmodule

/* rtl/cpp_token_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_token_scanner
// Streaming C++ lexical scanner: one source byte or end mark per item in,
// finished tokens out with length, line, error and suffix warning.
// ----------------------------------------------------------------------------
// path: input register, scan, four-entry queue, output
// throughput: one item per cycle while the queue holds at most two results;
//   an item gives at most two results; they leave one per cycle on i_ready
// reset: synchronous, active low; scanner idle, line count zero, queue empty
module cpp_token_scanner import cts_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_cts_in  i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_cts_out o_data
);

    localparam int NSTAGE = 4;

    logic       r_in_vld;
    t_cts_in    r_in;
    t_scan_st   r_st;
    logic       proc;
    logic [2:0] q_count;

    t_scan_st   st_chain  [NSTAGE+1];
    logic       act_chain [NSTAGE+1];
    logic       emit      [NSTAGE];
    t_cts_out   res       [NSTAGE];
    t_cts_out   wr_data   [4];
    logic [2:0] wr_cnt;

    assign proc    = r_in_vld && (q_count <= 3'd2);
    assign o_ready = !r_in_vld || proc;

    assign st_chain[0]  = r_st;
    assign act_chain[0] = 1'b1;

    for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
        cts_scan_stage u_stage (
            .i_active (act_chain[g]),
            .i_item   (r_in),
            .i_st     (st_chain[g]),
            .o_st     (st_chain[g+1]),
            .o_active (act_chain[g+1]),
            .o_emit   (emit[g]),
            .o_res    (res[g])
        );
    end

    // pack the results of the scans into consecutive queue slots
    always_comb begin
        wr_cnt = 3'd0;
        for (int k = 0; k < 4; k++) wr_data[k] = '0;
        for (int s = 0; s < NSTAGE; s++) begin
            if (emit[s]) begin
                wr_data[wr_cnt[1:0]] = res[s];
                wr_cnt = wr_cnt + 3'd1;
            end
        end
        for (int k = 0; k < 4; k++) wr_data[k].last = (3'(k + 1) == wr_cnt);
        if (!proc) wr_cnt = 3'd0;
    end

    cts_res_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_cnt  (wr_cnt),
        .i_wr_data (wr_data),
        .o_count   (q_count),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_st     <= '0;
        end else begin
            if (o_ready) r_in_vld <= i_valid;
            if (proc) r_st <= st_chain[NSTAGE];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in <= i_data;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams source bytes and end marks through the token scanner. A behavioural
// scanner works out the tokens each accepted item should give, and every
// token that leaves the block is checked field by field against them.
// ----------------------------------------------------------------------------
module testbench;
    import cts_pkg::*;

    localparam int unsigned END_MARK = 256;

    typedef struct {
        t_cts_in data;
        bit      hold_till_empty;
    } t_src_item;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_cts_in  i_data = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_cts_out o_data;

    cpp_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    t_src_item src_q[$];
    t_cts_out  token_q[$];
    t_cts_out  step_tokens[$];
    int        n_errors = 0;
    int        n_accepted = 0;
    int        n_tokens = 0;
    int        n_ends = 0;
    bit        taken = 1'b0;
    bit        rx_hold = 1'b0;
    bit        started = 1'b0;

    // scanner state
    logic [4:0]             sc_mode;
    logic [7:0]             sc_held;
    logic                   sc_warn;
    logic [LENGTH_BITS-1:0] sc_len;
    logic [LINE_BITS-1:0]   sc_line;
    logic [1:0]             sc_suf;
    logic [2:0]             sc_err;

    function automatic bit digit(int unsigned b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit letter(int unsigned b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic bit op_lead(int unsigned b);
        return b == "-" || b == "+" || b == "*" || b == "/" || b == "%" || b == "<" ||
               b == ">" || b == "=" || b == "!" || b == "^" || b == "&" || b == "|" ||
               b == ":";
    endfunction

    function automatic int unsigned upper(int unsigned b);
        return (b >= "a" && b <= "z") ? b - 32 : b;
    endfunction

    function automatic void grow(int unsigned n);
        sc_len = (int'(sc_len) + n > int'(LEN_MAX)) ? LEN_MAX :
                 LENGTH_BITS'(int'(sc_len) + n);
    endfunction

    function automatic void push_token(logic [5:0] k, logic [7:0] ch,
                                       logic [LENGTH_BITS-1:0] len, logic [2:0] err,
                                       logic warn);
        t_cts_out t;
        if (step_tokens.size() >= 3) return;
        t.token_kind = k;
        t.single_char = ch;
        t.token_length = len;
        t.line_number = sc_line;
        t.error_code = err;
        t.suffix_warning = warn;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void reset_token();
        sc_mode = M_IDLE;
        sc_held = '0;
        sc_warn = 1'b0;
        sc_len = '0;
        sc_suf = '0;
        sc_err = E_NONE;
    endfunction

    function automatic void close_token(logic [5:0] k, logic [7:0] ch);
        push_token(k, ch, sc_len, sc_err, sc_warn);
        reset_token();
    endfunction

    function automatic bit quoted(int unsigned b, int unsigned q, logic [4:0] esc,
                                  logic [2:0] err);
        grow(1);
        if (b == q) begin
            close_token(sc_held[5:0], 0);
            return 1;
        end
        if (b == "\\") begin
            sc_mode = esc;
            return 1;
        end
        if (b == "\n" || b == END_MARK) begin
            sc_err = err;
            close_token(sc_held[5:0], 0);
            return 0;
        end
        return 1;
    endfunction

    // returns 1 when the byte is used up, 0 when it is to be looked at again
    function automatic bit scan_one(int unsigned b);
        logic [5:0]  k;
        int unsigned s;
        logic [1:0]  m;
        case (sc_mode)
            M_IDLE: begin
                if (b == END_MARK) begin
                    push_token(K_END, 0, 0, E_NONE, 0);
                    sc_line = '0;
                    return 1;
                end
                if (b == " " || b == "\t") return 1;
                if (b == "\n") begin
                    if (sc_line != LINE_MAX) sc_line++;
                    return 1;
                end
                reset_token();
                sc_len = LENGTH_BITS'(1);
                if (letter(b) || b == "_") sc_mode = (b == "L") ? M_LPRE : M_NAME;
                else if (b == "0") sc_mode = M_ZERO;
                else if (digit(b)) sc_mode = M_DEC;
                else if (b == ".") sc_mode = M_DOT;
                else if (b == "\"") begin
                    sc_mode = M_STR;
                    sc_held = {2'b00, K_STR};
                end else if (b == "'") begin
                    sc_mode = M_CHR1;
                    sc_held = {2'b00, K_CHR};
                end else if (op_lead(b)) begin
                    sc_mode = M_OP1;
                    sc_held = b[7:0];
                end else close_token(K_SINGLE, b[7:0]);
                return 1;
            end
            M_NAME: begin
                if (letter(b) || digit(b) || b == "_") begin
                    grow(1);
                    return 1;
                end
                close_token(K_NAME, 0);
                return 0;
            end
            M_LPRE: begin
                if (b == "'" || b == "\"") begin
                    grow(1);
                    sc_mode = (b == "'") ? M_CHR1 : M_STR;
                    sc_held = (b == "'") ? {2'b00, K_WCHR} : {2'b00, K_WSTR};
                    return 1;
                end
                sc_mode = M_NAME;
                return 0;
            end
            M_ZERO, M_DEC: begin
                if (sc_mode == M_DEC && digit(b)) begin
                    grow(1);
                    return 1;
                end
                if (b == ".") begin
                    grow(1);
                    sc_mode = M_FRAC;
                    return 1;
                end
                if (b == "e" || b == "E") begin
                    grow(1);
                    sc_mode = M_EXP;
                    return 1;
                end
                if (sc_mode == M_ZERO && (b == "x" || b == "X")) begin
                    grow(1);
                    sc_mode = M_HEX;
                    sc_err = E_NO_HEX;
                    return 1;
                end
                if (sc_mode == M_ZERO && b >= "0" && b <= "7") begin
                    grow(1);
                    sc_mode = M_OCT;
                    return 1;
                end
                sc_mode = M_SUF;
                sc_held = {2'b00, K_INT_DEC};
                return 0;
            end
            M_HEX: begin
                if (digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
                    grow(1);
                    sc_err = E_NONE;
                    return 1;
                end
                sc_mode = M_SUF;
                sc_held = {2'b00, K_INT_HEX};
                return 0;
            end
            M_OCT: begin
                if (b >= "0" && b <= "7") begin
                    grow(1);
                    return 1;
                end
                sc_mode = M_SUF;
                sc_held = {2'b00, K_INT_OCT};
                return 0;
            end
            M_FRAC: begin
                if (digit(b)) begin
                    grow(1);
                    return 1;
                end
                if (b == "e" || b == "E") begin
                    grow(1);
                    sc_mode = M_EXP;
                    return 1;
                end
                sc_mode = M_SUF;
                sc_held = {2'b00, K_FLT};
                return 0;
            end
            M_EXP, M_EXPSGN: begin
                if (sc_mode == M_EXP && (b == "+" || b == "-")) begin
                    grow(1);
                    sc_mode = M_EXPSGN;
                    return 1;
                end
                if (digit(b)) begin
                    grow(1);
                    sc_mode = M_EXPDIG;
                    return 1;
                end
                sc_err = E_NO_EXP;
                close_token(K_FLT, 0);
                return 0;
            end
            M_EXPDIG: begin
                if (digit(b)) begin
                    grow(1);
                    return 1;
                end
                sc_mode = M_SUF;
                sc_held = {2'b00, K_FLT};
                return 0;
            end
            M_SUF: begin
                s = (sc_held == K_FLT) ? "F" : "U";
                if (upper(b) == "L" || upper(b) == s) begin
                    m = (upper(b) == "L") ? 2'b01 : 2'b10;
                    if ((sc_suf & m) != 0) sc_warn = 1'b1;
                    else begin
                        sc_suf |= m;
                        grow(1);
                    end
                    return 1;
                end
                if (sc_held == K_FLT) close_token(sc_suf[1] ? K_FLT_F : K_FLT, 0);
                else close_token(sc_held[5:0] + sc_suf[1], 0);
                return 0;
            end
            M_DOT: begin
                if (b == "*") begin
                    grow(1);
                    close_token(K_DOT_STAR, 0);
                    return 1;
                end
                if (b == "." || digit(b)) begin
                    grow(1);
                    sc_mode = (b == ".") ? M_DOTDOT : M_FRAC;
                    return 1;
                end
                close_token(K_SINGLE, ".");
                return 0;
            end
            M_DOTDOT: begin
                sc_len = LENGTH_BITS'(3);
                if (b == ".") begin
                    close_token(K_ELLIPSIS, 0);
                    return 1;
                end
                sc_err = E_DOT;
                close_token(K_ELLIPSIS, 0);
                return 0;
            end
            M_OP1: begin
                k = K_SINGLE;
                case (sc_held)
                    "-": k = (b == "-") ? K_DEC_DEC : (b == "=") ? K_SUB_EQ : K_SINGLE;
                    "+": k = (b == "+") ? K_INC : (b == "=") ? K_ADD_EQ : K_SINGLE;
                    "*": if (b == "=") k = K_MUL_EQ;
                    "/": if (b == "=") k = K_DIV_EQ;
                    "%": if (b == "=") k = K_MOD_EQ;
                    "<": if (b == "=") k = K_LE;
                    ">": if (b == "=") k = K_GE;
                    "=": if (b == "=") k = K_EQ;
                    "!": if (b == "=") k = K_NE;
                    "^": if (b == "=") k = K_XOR_EQ;
                    "&": k = (b == "=") ? K_AND_EQ : (b == "&") ? K_LAND : K_SINGLE;
                    "|": k = (b == "=") ? K_OR_EQ : (b == "|") ? K_LOR : K_SINGLE;
                    ":": if (b == ":") k = K_SCOPE;
                    default: k = K_SINGLE;
                endcase
                if (k != K_SINGLE) begin
                    grow(1);
                    close_token(k, 0);
                    return 1;
                end
                if ((sc_held == "-" && b == ">") || (sc_held == "<" && b == "<") ||
                    (sc_held == ">" && b == ">")) begin
                    grow(1);
                    sc_mode = M_OP2;
                    return 1;
                end
                close_token(K_SINGLE, sc_held);
                return 0;
            end
            M_OP2: begin
                if (b == ((sc_held == "-") ? "*" : "=")) begin
                    grow(1);
                    close_token((sc_held == "-") ? K_ARROW_STAR :
                                (sc_held == "<") ? K_SHL_EQ : K_SHR_EQ, 0);
                    return 1;
                end
                close_token((sc_held == "-") ? K_ARROW :
                            (sc_held == "<") ? K_SHL : K_SHR, 0);
                return 0;
            end
            M_STR: return quoted(b, "\"", M_STRESC, E_OPEN_STR);
            M_CHR: return quoted(b, "'", M_CHRESC, E_OPEN_CHR);
            M_STRESC, M_CHRESC: begin
                s = (sc_mode == M_STRESC) ? "\"" : "'";
                sc_mode = (sc_mode == M_STRESC) ? M_STR : M_CHR;
                if (b == s || b == "\\") begin
                    grow(1);
                    return 1;
                end
                return 0;
            end
            M_CHR1: begin
                if (b == "'") begin
                    grow(3);
                    sc_err = E_EMPTY_CHR;
                    close_token(sc_held[5:0], 0);
                    return 1;
                end
                sc_mode = M_CHR;
                return 0;
            end
            default: begin
                reset_token();
                return 0;
            end
        endcase
    endfunction

    function automatic void predict_tokens(t_cts_in it);
        int unsigned b;
        b = it.end_of_input ? END_MARK : it.src_byte;
        step_tokens.delete();
        for (int i = 0; i < 8; i++)
            if (scan_one(b)) break;
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
    endfunction

    task automatic report(string field, longint got, longint want);
        n_errors++;
        $display("mismatch at %0t on %s: got %0d, expected %0d", $realtime, field, got, want);
    endtask

    // stimulus helpers
    task automatic put(logic [7:0] b, bit eoi = 0, bit pause = 0);
        t_src_item s;
        s.data.src_byte = b;
        s.data.end_of_input = eoi;
        s.hold_till_empty = pause;
        src_q.push_back(s);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_digits(int n, int hi);
        repeat (n) put("0" + $urandom_range(0, hi));
    endtask

    task automatic put_suffix(string set);
        repeat ($urandom_range(0, 3)) put(set[$urandom_range(0, set.len() - 1)]);
    endtask

    task automatic put_snippet();
        string ops[$] = '{"--", "-=", "->*", "->", "++", "+=", "*=", "/=", "%=", "<=",
                          "<<=", "<<", ">=", ">>=", ">>", "==", "!=", "^=", "&=", "&&",
                          "|=", "||", "::", ".*", "...", "..", ".", "-", "+", "*", "<",
                          ">", "&", "|", ":", "!", "=", "^", "/", "%", "(", "}", ";"};
        string hexd = "0123456789abcdefABCDEF";
        string body = "ab \\\\\"'x_9";
        int    q;
        case ($urandom_range(0, 15))
            0, 1: begin
                if ($urandom_range(0, 3) == 0) put("L");
                else put(($urandom_range(0, 4) == 0) ? "_" : "a" + $urandom_range(0, 25));
                repeat ($urandom_range(0, 5))
                    put(($urandom_range(0, 2) == 0) ? "0" + $urandom_range(0, 9) :
                        ($urandom_range(0, 1) ? "A" : "a") + $urandom_range(0, 25));
            end
            2: begin
                put("1" + $urandom_range(0, 8));
                put_digits($urandom_range(0, 4), 9);
                put_suffix("uUlL");
            end
            3: begin
                put_text($urandom_range(0, 1) ? "0x" : "0X");
                repeat ($urandom_range(0, 3)) put(hexd[$urandom_range(0, hexd.len() - 1)]);
                put_suffix("uUlL");
            end
            4: begin
                put("0");
                put_digits($urandom_range(0, 3), 7);
                put_suffix("uUlL");
            end
            5, 6: begin
                put_digits($urandom_range(0, 3), 9);
                if ($urandom_range(0, 3) != 0) put(".");
                put_digits($urandom_range(0, 2), 9);
                if ($urandom_range(0, 1)) begin
                    put($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1)) put($urandom_range(0, 1) ? "+" : "-");
                    put_digits($urandom_range(0, 2), 9);
                end
                put_suffix("fFlL");
            end
            7, 8: begin
                q = $urandom_range(0, 1) ? "\"" : "'";
                if ($urandom_range(0, 3) == 0) put("L");
                put(q);
                repeat ($urandom_range(0, 5)) put(body[$urandom_range(0, body.len() - 1)]);
                case ($urandom_range(0, 5))
                    0: put("\n");
                    1: ;
                    default: put(q);
                endcase
            end
            9, 10, 11: put_text(ops[$urandom_range(0, ops.size() - 1)]);
            12: put($urandom_range(0, 255));
            13: put(($urandom_range(0, 1)) ? "\n" : "\t");
            14: put(0, 1);
            default: put(" ");
        endcase
        case ($urandom_range(0, 3))
            0: put(" ");
            1: put("\n");
            default: ;
        endcase
    endtask

    initial begin
        // directed: wide and empty literals, two dots, open literal, missing
        // exponent and hex digits, repeated suffix, longest operators
        put_text("L''..x0x 1e+z7uU");
        put_text("\"\\\\\n->*<<=");
        put(8'hff);
        put(0, 1, 1);
        while (src_q.size() < 470) begin
            if (src_q.size() > 300 && src_q.size() < 320) put(" ", 0, 1);
            put_snippet();
        end
        put(0, 1);
    end

    // reset and both sides of the handshake
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        started = 1'b1;
    end

    always @(posedge i_clk) taken <= i_valid && o_ready;

    always @(negedge i_clk) begin
        int send_idle;
        send_idle = (n_accepted < 160) ? 26 : (n_accepted < 320) ? 47 : 0;
        if (started) begin
            if (i_valid && !taken) begin
                i_valid <= 1'b1;
            end else if (src_q.size() > 0 && $urandom_range(0, 99) >= send_idle &&
                         !(src_q[0].hold_till_empty && token_q.size() != 0)) begin
                i_data <= src_q[0].data;
                i_valid <= 1'b1;
                void'(src_q.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        int stall;
        stall = (n_accepted < 160) ? 47 : (n_accepted < 320) ? 26 : 0;
        i_ready <= started && !rx_hold && $urandom_range(0, 99) >= stall;
    end

    // long receiver stall so the output queue fills and input backs up
    initial begin
        while (n_accepted < 100) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (80) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_cts_out want;
        if (i_rst_n && i_valid && o_ready) begin
            if (n_accepted == 0) begin
                reset_token();
                sc_line = '0;
            end
            predict_tokens(i_data);
            n_accepted++;
        end
        if (i_rst_n && o_valid && i_ready) begin
            n_tokens++;
            if (token_q.size() == 0) begin
                report("unexpected token kind", o_data.token_kind, -1);
            end else begin
                want = token_q.pop_front();
                if (o_data.token_kind == K_END) n_ends++;
                if (o_data.token_kind !== want.token_kind)
                    report("token_kind", o_data.token_kind, want.token_kind);
                if (o_data.single_char !== want.single_char)
                    report("single_char", o_data.single_char, want.single_char);
                if (o_data.token_length !== want.token_length)
                    report("token_length", o_data.token_length, want.token_length);
                if (o_data.line_number !== want.line_number)
                    report("line_number", o_data.line_number, want.line_number);
                if (o_data.error_code !== want.error_code)
                    report("error_code", o_data.error_code, want.error_code);
                if (o_data.suffix_warning !== want.suffix_warning)
                    report("suffix_warning", o_data.suffix_warning, want.suffix_warning);
                if (o_data.last !== want.last)
                    report("last", o_data.last, want.last);
            end
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (src_q.size() != 0 || i_valid || token_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (token_q.size() != 0) report("tokens outstanding", token_q.size(), 0);
        $display("%0d source items scanned, %0d tokens checked, %0d end marks",
                 n_accepted, n_tokens, n_ends);
        $display("mixed names, numbers, literals, operators and noise under stalls");
        if (n_errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
